// ===== rtl/rvdec_pkg.sv =====
// rvdec_pkg: shared types and constants for the rv32i instruction decoder
// opcode and funct codes, result code enums, control flag masks, decoded record
// no dependencies
package rvdec_pkg;

  // major opcodes
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  // funct7 values
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // system immediates
  localparam logic [11:0] SYS_ECALL  = 12'h000;
  localparam logic [11:0] SYS_EBREAK = 12'h001;

  // control flag masks
  localparam logic [7:0] FLAG_REG_WRITE = 8'h01;
  localparam logic [7:0] FLAG_MEM_READ  = 8'h02;
  localparam logic [7:0] FLAG_MEM_WRITE = 8'h04;
  localparam logic [7:0] FLAG_SRC_IMM   = 8'h08;
  localparam logic [7:0] FLAG_SRC_PC    = 8'h10;
  localparam logic [7:0] FLAG_BRANCH    = 8'h20;
  localparam logic [7:0] FLAG_JUMP      = 8'h40;
  localparam logic [7:0] FLAG_MEM_UNS   = 8'h80;

  typedef enum logic [5:0] {
    K_INVALID = 6'd0,
    K_ADD   = 6'd1,  K_SUB   = 6'd2,  K_SLL   = 6'd3,  K_SLT   = 6'd4,
    K_SLTU  = 6'd5,  K_XOR   = 6'd6,  K_SRL   = 6'd7,  K_SRA   = 6'd8,
    K_OR    = 6'd9,  K_AND   = 6'd10, K_ADDI  = 6'd11, K_SLTI  = 6'd12,
    K_SLTIU = 6'd13, K_XORI  = 6'd14, K_ORI   = 6'd15, K_ANDI  = 6'd16,
    K_SLLI  = 6'd17, K_SRLI  = 6'd18, K_SRAI  = 6'd19, K_LB    = 6'd20,
    K_LH    = 6'd21, K_LW    = 6'd22, K_LBU   = 6'd23, K_LHU   = 6'd24,
    K_SB    = 6'd25, K_SH    = 6'd26, K_SW    = 6'd27, K_BEQ   = 6'd28,
    K_BNE   = 6'd29, K_BLT   = 6'd30, K_BGE   = 6'd31, K_BLTU  = 6'd32,
    K_BGEU  = 6'd33, K_LUI   = 6'd34, K_AUIPC = 6'd35, K_JAL   = 6'd36,
    K_JALR  = 6'd37, K_ECALL = 6'd38, K_EBREAK = 6'd39
  } kind_t;

  typedef enum logic [2:0] {
    FMT_NONE = 3'd0, FMT_R = 3'd1, FMT_I = 3'd2, FMT_S = 3'd3,
    FMT_B = 3'd4, FMT_U = 3'd5, FMT_J = 3'd6
  } format_t;

  typedef enum logic [3:0] {
    ALU_NONE = 4'd0, ALU_ADD = 4'd1, ALU_SUB = 4'd2, ALU_SLL = 4'd3,
    ALU_SLT = 4'd4, ALU_SLTU = 4'd5, ALU_XOR = 4'd6, ALU_SRL = 4'd7,
    ALU_SRA = 4'd8, ALU_OR = 4'd9, ALU_AND = 4'd10
  } alu_t;

  typedef enum logic [2:0] {
    WB_NONE = 3'd0, WB_ALU = 3'd1, WB_MEM = 3'd2, WB_IMM = 3'd3, WB_PC4 = 3'd4
  } wb_t;

  typedef enum logic [1:0] {
    MW_NONE = 2'd0, MW_BYTE = 2'd1, MW_HALF = 2'd2, MW_WORD = 2'd3
  } mem_width_t;

  typedef enum logic [2:0] {
    BC_NONE = 3'd0, BC_EQ = 3'd1, BC_NE = 3'd2, BC_LT = 3'd3,
    BC_GE = 3'd4, BC_LTU = 3'd5, BC_GEU = 3'd6
  } branch_cond_t;

  typedef struct packed {
    kind_t               kind;
    format_t             format;
    logic [4:0]          dest_reg;
    logic [4:0]          src_reg_a;
    logic [4:0]          src_reg_b;
    logic signed [31:0]  imm_value;
    alu_t                alu;
    wb_t                 wb;
    logic [7:0]          flags;
    mem_width_t          mem_width;
    branch_cond_t        branch_cond;
  } dec_t;

endpackage

// ===== rtl/rvdec_if.sv =====
// rvdec_in_if / rvdec_out_if: valid/ready channels of the instruction decoder
// depends on nothing; payload widths follow the decoder's item fields
interface rvdec_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;

  modport source(output valid, output instr_word, input ready);
  modport sink(input valid, input instr_word, output ready);
endinterface

interface rvdec_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         instr_kind;
  logic [2:0]         instr_format;
  logic [4:0]         dest_reg;
  logic [4:0]         src_reg_a;
  logic [4:0]         src_reg_b;
  logic signed [31:0] imm_value;
  logic [3:0]         alu_select;
  logic [2:0]         wb_source;
  logic [7:0]         ctrl_flags;
  logic [1:0]         mem_width;
  logic [2:0]         branch_cond;

  modport source(
    output valid, output instr_kind, output instr_format, output dest_reg,
    output src_reg_a, output src_reg_b, output imm_value, output alu_select,
    output wb_source, output ctrl_flags, output mem_width, output branch_cond,
    input ready
  );
  modport sink(
    input valid, input instr_kind, input instr_format, input dest_reg,
    input src_reg_a, input src_reg_b, input imm_value, input alu_select,
    input wb_source, input ctrl_flags, input mem_width, input branch_cond,
    output ready
  );
endinterface

// ===== rtl/rv32i_instruction_decoder.sv =====
// rv32i_instruction_decoder: two-register decode pipeline for rv32i words
// depends on rvdec_pkg and the channel interfaces in rvdec_if.sv
//
// usage
//   instr_ch carries one raw 32-bit instruction word per item; dec_ch carries
//   the decoded record: kind, format, rd/rs1/rs2, sign-extended immediate and
//   the pipeline controls (alu op, writeback source, flags, width, condition)
//   an item is moved on any rising edge where valid and ready are both high
// timing
//   the word is captured in an input register, decoded by one shallow level of
//   opcode/funct logic and stored in the result register once that register is
//   free (empty or being taken); dec_ch is driven from the result register
//   one item per cycle sustained; the only limit is the result register
//   draining, so instr_ch.ready stays high as long as dec_ch is taking items
// stall
//   when dec_ch.ready is low the result holds; the input register can still
//   take one more item, after which instr_ch.ready drops until space frees up
// reset
//   rst (synchronous) empties both registers; no item is in flight afterwards
//   and the decoder itself holds no other state
module rv32i_instruction_decoder
  import rvdec_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  rvdec_in_if.sink     instr_ch,
  rvdec_out_if.source  dec_ch
);

  // input register
  logic        s1_valid;
  logic [31:0] s1_word;

  // result register
  logic        out_valid;
  dec_t        out_dec;

  dec_t        dec_next;

  logic        out_free;
  logic        s1_free;

  assign out_free        = !out_valid || dec_ch.ready;
  assign s1_free         = !s1_valid || out_free;
  assign instr_ch.ready  = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= instr_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && instr_ch.valid) begin
      s1_word <= instr_ch.instr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_dec <= dec_next;
    end
  end

  // decode of the word held in the input register
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_u;
  logic [31:0] imm_j;

  assign opc   = s1_word[6:0];
  assign f3    = s1_word[14:12];
  assign f7    = s1_word[31:25];
  assign imm_i = {{20{s1_word[31]}}, s1_word[31:20]};
  assign imm_s = {{20{s1_word[31]}}, s1_word[31:25], s1_word[11:7]};
  assign imm_b = {{19{s1_word[31]}}, s1_word[31], s1_word[7], s1_word[30:25],
                  s1_word[11:8], 1'b0};
  assign imm_u = {s1_word[31:12], 12'b0};
  assign imm_j = {{11{s1_word[31]}}, s1_word[31], s1_word[19:12], s1_word[20],
                  s1_word[30:21], 1'b0};

  always_comb begin
    dec_next           = '0;
    // register fields come straight from the word whatever the opcode
    dec_next.dest_reg  = s1_word[11:7];
    dec_next.src_reg_a = s1_word[19:15];
    dec_next.src_reg_b = s1_word[24:20];

    case (opc)
      OPC_OP: begin
        dec_next.format = FMT_R;
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0: begin dec_next.kind = K_ADD;  dec_next.alu = ALU_ADD;  end
            3'd1: begin dec_next.kind = K_SLL;  dec_next.alu = ALU_SLL;  end
            3'd2: begin dec_next.kind = K_SLT;  dec_next.alu = ALU_SLT;  end
            3'd3: begin dec_next.kind = K_SLTU; dec_next.alu = ALU_SLTU; end
            3'd4: begin dec_next.kind = K_XOR;  dec_next.alu = ALU_XOR;  end
            3'd5: begin dec_next.kind = K_SRL;  dec_next.alu = ALU_SRL;  end
            3'd6: begin dec_next.kind = K_OR;   dec_next.alu = ALU_OR;   end
            default: begin dec_next.kind = K_AND; dec_next.alu = ALU_AND; end
          endcase
        end else if (f7 == F7_ALT && f3 == 3'd0) begin
          dec_next.kind = K_SUB;
          dec_next.alu  = ALU_SUB;
        end else if (f7 == F7_ALT && f3 == 3'd5) begin
          dec_next.kind = K_SRA;
          dec_next.alu  = ALU_SRA;
        end
        if (dec_next.kind != K_INVALID) begin
          dec_next.wb    = WB_ALU;
          dec_next.flags = FLAG_REG_WRITE;
        end
      end

      OPC_OP_IMM: begin
        dec_next.format    = FMT_I;
        dec_next.imm_value = imm_i;
        case (f3)
          3'd0: begin dec_next.kind = K_ADDI;  dec_next.alu = ALU_ADD;  end
          3'd2: begin dec_next.kind = K_SLTI;  dec_next.alu = ALU_SLT;  end
          3'd3: begin dec_next.kind = K_SLTIU; dec_next.alu = ALU_SLTU; end
          3'd4: begin dec_next.kind = K_XORI;  dec_next.alu = ALU_XOR;  end
          3'd6: begin dec_next.kind = K_ORI;   dec_next.alu = ALU_OR;   end
          3'd7: begin dec_next.kind = K_ANDI;  dec_next.alu = ALU_AND;  end
          3'd1: begin
            if (f7 == F7_BASE) begin
              dec_next.kind = K_SLLI;
              dec_next.alu  = ALU_SLL;
            end
          end
          default: begin
            if (f7 == F7_BASE) begin
              dec_next.kind = K_SRLI;
              dec_next.alu  = ALU_SRL;
            end else if (f7 == F7_ALT) begin
              dec_next.kind = K_SRAI;
              dec_next.alu  = ALU_SRA;
            end
          end
        endcase
        // valid shift immediates keep only the shift amount
        if (dec_next.kind == K_SLLI || dec_next.kind == K_SRLI ||
            dec_next.kind == K_SRAI) begin
          dec_next.imm_value = {27'b0, s1_word[24:20]};
        end
        if (dec_next.kind != K_INVALID) begin
          dec_next.wb    = WB_ALU;
          dec_next.flags = FLAG_REG_WRITE | FLAG_SRC_IMM;
        end
      end

      OPC_LOAD: begin
        dec_next.format    = FMT_I;
        dec_next.imm_value = imm_i;
        case (f3)
          3'd0: begin dec_next.kind = K_LB;  dec_next.mem_width = MW_BYTE; end
          3'd1: begin dec_next.kind = K_LH;  dec_next.mem_width = MW_HALF; end
          3'd2: begin dec_next.kind = K_LW;  dec_next.mem_width = MW_WORD; end
          3'd4: begin dec_next.kind = K_LBU; dec_next.mem_width = MW_BYTE; end
          3'd5: begin dec_next.kind = K_LHU; dec_next.mem_width = MW_HALF; end
          default: begin
            dec_next.kind = K_INVALID;
          end
        endcase
        if (dec_next.kind != K_INVALID) begin
          dec_next.alu   = ALU_ADD;
          dec_next.wb    = WB_MEM;
          dec_next.flags = FLAG_REG_WRITE | FLAG_MEM_READ | FLAG_SRC_IMM;
          if (dec_next.kind == K_LBU || dec_next.kind == K_LHU) begin
            dec_next.flags = dec_next.flags | FLAG_MEM_UNS;
          end
        end
      end

      OPC_STORE: begin
        dec_next.format    = FMT_S;
        dec_next.imm_value = imm_s;
        case (f3)
          3'd0: begin dec_next.kind = K_SB; dec_next.mem_width = MW_BYTE; end
          3'd1: begin dec_next.kind = K_SH; dec_next.mem_width = MW_HALF; end
          3'd2: begin dec_next.kind = K_SW; dec_next.mem_width = MW_WORD; end
          default: begin
            dec_next.kind = K_INVALID;
          end
        endcase
        if (dec_next.kind != K_INVALID) begin
          dec_next.alu   = ALU_ADD;
          dec_next.flags = FLAG_MEM_WRITE | FLAG_SRC_IMM;
        end
      end

      OPC_BRANCH: begin
        dec_next.format    = FMT_B;
        dec_next.imm_value = imm_b;
        case (f3)
          3'd0: begin dec_next.kind = K_BEQ;  dec_next.branch_cond = BC_EQ;  end
          3'd1: begin dec_next.kind = K_BNE;  dec_next.branch_cond = BC_NE;  end
          3'd4: begin dec_next.kind = K_BLT;  dec_next.branch_cond = BC_LT;  end
          3'd5: begin dec_next.kind = K_BGE;  dec_next.branch_cond = BC_GE;  end
          3'd6: begin dec_next.kind = K_BLTU; dec_next.branch_cond = BC_LTU; end
          3'd7: begin dec_next.kind = K_BGEU; dec_next.branch_cond = BC_GEU; end
          default: begin
            dec_next.kind = K_INVALID;
          end
        endcase
        if (dec_next.kind != K_INVALID) begin
          dec_next.alu   = ALU_SUB;
          dec_next.flags = FLAG_BRANCH;
        end
      end

      OPC_LUI: begin
        dec_next.format    = FMT_U;
        dec_next.imm_value = imm_u;
        dec_next.kind      = K_LUI;
        dec_next.wb        = WB_IMM;
        dec_next.flags     = FLAG_REG_WRITE;
      end

      OPC_AUIPC: begin
        dec_next.format    = FMT_U;
        dec_next.imm_value = imm_u;
        dec_next.kind      = K_AUIPC;
        dec_next.alu       = ALU_ADD;
        dec_next.wb        = WB_ALU;
        dec_next.flags     = FLAG_REG_WRITE | FLAG_SRC_PC | FLAG_SRC_IMM;
      end

      OPC_JAL: begin
        dec_next.format    = FMT_J;
        dec_next.imm_value = imm_j;
        dec_next.kind      = K_JAL;
        dec_next.alu       = ALU_ADD;
        dec_next.wb        = WB_PC4;
        dec_next.flags     = FLAG_REG_WRITE | FLAG_JUMP | FLAG_SRC_PC | FLAG_SRC_IMM;
      end

      OPC_JALR: begin
        dec_next.format    = FMT_I;
        dec_next.imm_value = imm_i;
        if (f3 == 3'd0) begin
          dec_next.kind  = K_JALR;
          dec_next.alu   = ALU_ADD;
          dec_next.wb    = WB_PC4;
          dec_next.flags = FLAG_REG_WRITE | FLAG_JUMP | FLAG_SRC_IMM;
        end
      end

      OPC_SYSTEM: begin
        // ecall and ebreak carry no controls; rd and rs1 are not checked
        dec_next.format    = FMT_I;
        dec_next.imm_value = imm_i;
        if (f3 == 3'd0 && s1_word[31:20] == SYS_ECALL) begin
          dec_next.kind = K_ECALL;
        end else if (f3 == 3'd0 && s1_word[31:20] == SYS_EBREAK) begin
          dec_next.kind = K_EBREAK;
        end
      end

      default: begin
        dec_next.format = FMT_NONE;
      end
    endcase
  end

  // result channel
  assign dec_ch.valid        = out_valid;
  assign dec_ch.instr_kind   = out_dec.kind;
  assign dec_ch.instr_format = out_dec.format;
  assign dec_ch.dest_reg     = out_dec.dest_reg;
  assign dec_ch.src_reg_a    = out_dec.src_reg_a;
  assign dec_ch.src_reg_b    = out_dec.src_reg_b;
  assign dec_ch.imm_value    = out_dec.imm_value;
  assign dec_ch.alu_select   = out_dec.alu;
  assign dec_ch.wb_source    = out_dec.wb;
  assign dec_ch.ctrl_flags   = out_dec.flags;
  assign dec_ch.mem_width    = out_dec.mem_width;
  assign dec_ch.branch_cond  = out_dec.branch_cond;

endmodule

// ===== rtl/rvdec_checker.sv =====
// rvdec_checker: port-level assertions for rv32i_instruction_decoder
// depends on rvdec_pkg; bound to rv32i_instruction_decoder at the end of this file
module rvdec_checker
  import rvdec_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [5:0]         instr_kind,
  input logic [2:0]         instr_format,
  input logic signed [31:0] imm_value,
  input logic [3:0]         alu_select,
  input logic [2:0]         wb_source,
  input logic [7:0]         ctrl_flags,
  input logic [1:0]         mem_width,
  input logic [2:0]         branch_cond
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(instr_kind) && $stable(imm_value) &&
      $stable(ctrl_flags))
    else $error("result payload changed while stalled");

  // an accepted word reaches the output when the sink is ready while it sits in the input register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted item did not reach the output");

  // an invalid kind carries no controls
  a_invalid_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && instr_kind == K_INVALID |->
      alu_select == ALU_NONE && wb_source == WB_NONE && ctrl_flags == 8'h00 &&
      mem_width == MW_NONE && branch_cond == BC_NONE)
    else $error("controls set for an invalid instruction");

  // a recognized kind always has a format
  a_kind_format: assert property (@(posedge clk) disable iff (rst)
    out_valid && instr_kind != K_INVALID |-> instr_format != FMT_NONE)
    else $error("valid kind without a format");

endmodule

bind rv32i_instruction_decoder rvdec_checker u_rvdec_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (instr_ch.valid),
  .in_ready     (instr_ch.ready),
  .out_valid    (dec_ch.valid),
  .out_ready    (dec_ch.ready),
  .instr_kind   (dec_ch.instr_kind),
  .instr_format (dec_ch.instr_format),
  .imm_value    (dec_ch.imm_value),
  .alu_select   (dec_ch.alu_select),
  .wb_source    (dec_ch.wb_source),
  .ctrl_flags   (dec_ch.ctrl_flags),
  .mem_width    (dec_ch.mem_width),
  .branch_cond  (dec_ch.branch_cond)
);

// ===== verif/rv32i_instruction_decoder_tb.sv =====
// rv32i_instruction_decoder_tb: self-checking bench for the rv32i instruction decoder
// depends on rvdec_pkg, the channel interfaces in rvdec_if.sv and the decoder rtl
// directed corner words, a sweep of every kind, then random words under bursty traffic
`timescale 1ns / 100ps

module rv32i_instruction_decoder_tb;
  import rvdec_pkg::*;

  // funct3 encodings, grouped by the opcode they belong to
  localparam logic [2:0] F3_ADD_SUB = 3'd0;
  localparam logic [2:0] F3_SLL     = 3'd1;
  localparam logic [2:0] F3_SLT     = 3'd2;
  localparam logic [2:0] F3_SLTU    = 3'd3;
  localparam logic [2:0] F3_XOR     = 3'd4;
  localparam logic [2:0] F3_SR      = 3'd5;
  localparam logic [2:0] F3_OR      = 3'd6;
  localparam logic [2:0] F3_AND     = 3'd7;
  localparam logic [2:0] F3_B       = 3'd0;
  localparam logic [2:0] F3_H       = 3'd1;
  localparam logic [2:0] F3_W       = 3'd2;
  localparam logic [2:0] F3_BU      = 3'd4;
  localparam logic [2:0] F3_HU      = 3'd5;
  localparam logic [2:0] F3_BEQ     = 3'd0;
  localparam logic [2:0] F3_BNE     = 3'd1;
  localparam logic [2:0] F3_BLT     = 3'd4;
  localparam logic [2:0] F3_BGE     = 3'd5;
  localparam logic [2:0] F3_BLTU    = 3'd6;
  localparam logic [2:0] F3_BGEU    = 3'd7;
  localparam logic [2:0] F3_ZERO    = 3'd0;
  // encodings with no instruction behind them
  localparam logic [2:0] F3_BAD_LOAD   = 3'd3;
  localparam logic [2:0] F3_BAD_STORE  = 3'd3;
  localparam logic [2:0] F3_BAD_BRANCH = 3'd2;
  localparam logic [2:0] F3_BAD_JALR   = 3'd1;
  localparam logic [2:0] F3_CSRRW      = 3'd1;
  localparam logic [6:0] F7_BAD        = 7'h01;

  localparam int unsigned RANDOM_WORDS = 1800;
  localparam int unsigned DRAIN_EVERY  = 450;   // sender waits for an empty pipe this often
  localparam int unsigned HOLD_LEN     = 64;    // long receiver hold-off, in cycles
  localparam int unsigned HOLD_EVERY   = 900;
  localparam int unsigned TAIL_CYCLES  = 10;    // pipe is 2 deep, give it a margin

  typedef struct {
    logic [31:0] word;
    bit          wait_drain;   // hold this word back until nothing is in flight
  } word_item_t;

  typedef struct {
    logic [31:0] word;
    dec_t        rec;
  } decoded_item_t;

  typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_TRICKLE} rx_mode_t;

  logic clk = 1'b0;
  logic rst;

  rvdec_in_if  instr_ch ();
  rvdec_out_if dec_ch ();

  rv32i_instruction_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .instr_ch (instr_ch),
    .dec_ch   (dec_ch)
  );

  always #4 clk = ~clk;

  // words waiting to be sent, filled once at time zero
  word_item_t  word_q[$];
  // decoded records still owed by the block, oldest first
  decoded_item_t decoded_q[$];

  // cross-process status, all written with nonblocking assignments
  bit          pipe_empty = 1'b1;
  int unsigned words_accepted = 0;
  int unsigned results_seen = 0;

  int unsigned mismatch_cnt = 0;
  int unsigned invalid_cnt = 0;
  bit [39:0]   kinds_hit = '0;

  // ---------------------------------------------------------------------------
  // decode predictor: what the block should produce for one instruction word
  // ---------------------------------------------------------------------------
  function automatic dec_t decode_word(logic [31:0] w);
    dec_t        d;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    d = '0;
    f3 = w[14:12];
    f7 = w[31:25];
    imm_i = {{20{w[31]}}, w[31:20]};
    // register fields come straight from the word, whatever the opcode
    d.dest_reg  = w[11:7];
    d.src_reg_a = w[19:15];
    d.src_reg_b = w[24:20];
    case (w[6:0])
      OPC_OP: begin
        d.format = FMT_R;
        case ({f7, f3})
          {F7_BASE, F3_ADD_SUB}: begin d.kind = K_ADD;  d.alu = ALU_ADD;  end
          {F7_ALT,  F3_ADD_SUB}: begin d.kind = K_SUB;  d.alu = ALU_SUB;  end
          {F7_BASE, F3_SLL}:     begin d.kind = K_SLL;  d.alu = ALU_SLL;  end
          {F7_BASE, F3_SLT}:     begin d.kind = K_SLT;  d.alu = ALU_SLT;  end
          {F7_BASE, F3_SLTU}:    begin d.kind = K_SLTU; d.alu = ALU_SLTU; end
          {F7_BASE, F3_XOR}:     begin d.kind = K_XOR;  d.alu = ALU_XOR;  end
          {F7_BASE, F3_SR}:      begin d.kind = K_SRL;  d.alu = ALU_SRL;  end
          {F7_ALT,  F3_SR}:      begin d.kind = K_SRA;  d.alu = ALU_SRA;  end
          {F7_BASE, F3_OR}:      begin d.kind = K_OR;   d.alu = ALU_OR;   end
          {F7_BASE, F3_AND}:     begin d.kind = K_AND;  d.alu = ALU_AND;  end
          default: ;
        endcase
        if (d.kind != K_INVALID) begin
          d.wb = WB_ALU;
          d.flags = FLAG_REG_WRITE;
        end
      end
      OPC_OP_IMM: begin
        d.format = FMT_I;
        d.imm_value = imm_i;
        case (f3)
          F3_ADD_SUB: begin d.kind = K_ADDI;  d.alu = ALU_ADD;  end
          F3_SLT:     begin d.kind = K_SLTI;  d.alu = ALU_SLT;  end
          F3_SLTU:    begin d.kind = K_SLTIU; d.alu = ALU_SLTU; end
          F3_XOR:     begin d.kind = K_XORI;  d.alu = ALU_XOR;  end
          F3_OR:      begin d.kind = K_ORI;   d.alu = ALU_OR;   end
          F3_AND:     begin d.kind = K_ANDI;  d.alu = ALU_AND;  end
          F3_SLL: begin
            if (f7 == F7_BASE) begin d.kind = K_SLLI; d.alu = ALU_SLL; end
          end
          F3_SR: begin
            if (f7 == F7_BASE) begin
              d.kind = K_SRLI;
              d.alu = ALU_SRL;
            end else if (f7 == F7_ALT) begin
              d.kind = K_SRAI;
              d.alu = ALU_SRA;
            end
          end
          default: ;
        endcase
        // only a well-formed shift gets its amount cut down to 5 bits
        if (d.kind inside {K_SLLI, K_SRLI, K_SRAI})
          d.imm_value = {27'd0, w[24:20]};
        if (d.kind != K_INVALID) begin
          d.wb = WB_ALU;
          d.flags = FLAG_REG_WRITE | FLAG_SRC_IMM;
        end
      end
      OPC_LOAD: begin
        d.format = FMT_I;
        d.imm_value = imm_i;
        case (f3)
          F3_B:  begin d.kind = K_LB;  d.mem_width = MW_BYTE; end
          F3_H:  begin d.kind = K_LH;  d.mem_width = MW_HALF; end
          F3_W:  begin d.kind = K_LW;  d.mem_width = MW_WORD; end
          F3_BU: begin d.kind = K_LBU; d.mem_width = MW_BYTE; end
          F3_HU: begin d.kind = K_LHU; d.mem_width = MW_HALF; end
          default: ;
        endcase
        if (d.kind != K_INVALID) begin
          d.alu = ALU_ADD;
          d.wb = WB_MEM;
          d.flags = FLAG_REG_WRITE | FLAG_MEM_READ | FLAG_SRC_IMM;
          if (d.kind inside {K_LBU, K_LHU})
            d.flags = d.flags | FLAG_MEM_UNS;
        end
      end
      OPC_STORE: begin
        d.format = FMT_S;
        d.imm_value = {{20{w[31]}}, w[31:25], w[11:7]};
        case (f3)
          F3_B: begin d.kind = K_SB; d.mem_width = MW_BYTE; end
          F3_H: begin d.kind = K_SH; d.mem_width = MW_HALF; end
          F3_W: begin d.kind = K_SW; d.mem_width = MW_WORD; end
          default: ;
        endcase
        if (d.kind != K_INVALID) begin
          d.alu = ALU_ADD;
          d.flags = FLAG_MEM_WRITE | FLAG_SRC_IMM;
        end
      end
      OPC_BRANCH: begin
        d.format = FMT_B;
        d.imm_value = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        case (f3)
          F3_BEQ:  begin d.kind = K_BEQ;  d.branch_cond = BC_EQ;  end
          F3_BNE:  begin d.kind = K_BNE;  d.branch_cond = BC_NE;  end
          F3_BLT:  begin d.kind = K_BLT;  d.branch_cond = BC_LT;  end
          F3_BGE:  begin d.kind = K_BGE;  d.branch_cond = BC_GE;  end
          F3_BLTU: begin d.kind = K_BLTU; d.branch_cond = BC_LTU; end
          F3_BGEU: begin d.kind = K_BGEU; d.branch_cond = BC_GEU; end
          default: ;
        endcase
        if (d.kind != K_INVALID) begin
          d.alu = ALU_SUB;
          d.flags = FLAG_BRANCH;
        end
      end
      OPC_LUI: begin
        d.format = FMT_U;
        d.imm_value = {w[31:12], 12'd0};
        d.kind = K_LUI;
        d.wb = WB_IMM;
        d.flags = FLAG_REG_WRITE;
      end
      OPC_AUIPC: begin
        d.format = FMT_U;
        d.imm_value = {w[31:12], 12'd0};
        d.kind = K_AUIPC;
        d.alu = ALU_ADD;
        d.wb = WB_ALU;
        d.flags = FLAG_REG_WRITE | FLAG_SRC_PC | FLAG_SRC_IMM;
      end
      OPC_JAL: begin
        d.format = FMT_J;
        d.imm_value = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        d.kind = K_JAL;
        d.alu = ALU_ADD;
        d.wb = WB_PC4;
        d.flags = FLAG_REG_WRITE | FLAG_JUMP | FLAG_SRC_PC | FLAG_SRC_IMM;
      end
      OPC_JALR: begin
        d.format = FMT_I;
        d.imm_value = imm_i;
        if (f3 == F3_ZERO) begin
          d.kind = K_JALR;
          d.alu = ALU_ADD;
          d.wb = WB_PC4;
          d.flags = FLAG_REG_WRITE | FLAG_JUMP | FLAG_SRC_IMM;
        end
      end
      OPC_SYSTEM: begin
        // ecall / ebreak carry no controls; rd and rs1 are not looked at
        d.format = FMT_I;
        d.imm_value = imm_i;
        if (f3 == F3_ZERO && w[31:20] == SYS_ECALL)
          d.kind = K_ECALL;
        else if (f3 == F3_ZERO && w[31:20] == SYS_EBREAK)
          d.kind = K_EBREAK;
      end
      default: ;
    endcase
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  // force the opcode / funct bits of a random word so that it decodes as kind k
  function automatic logic [31:0] make_word(kind_t k, logic [31:0] w);
    logic [6:0] opc;
    logic [2:0] f3;
    bit         set_f3;
    bit         set_f7;
    set_f3 = 1'b1;
    set_f7 = 1'b0;
    f3 = F3_ZERO;
    case (k)
      K_ADD, K_SUB, K_ADDI:   f3 = F3_ADD_SUB;
      K_SLL, K_SLLI:          f3 = F3_SLL;
      K_SLT, K_SLTI:          f3 = F3_SLT;
      K_SLTU, K_SLTIU:        f3 = F3_SLTU;
      K_XOR, K_XORI:          f3 = F3_XOR;
      K_SRL, K_SRA, K_SRLI, K_SRAI: f3 = F3_SR;
      K_OR, K_ORI:            f3 = F3_OR;
      K_AND, K_ANDI:          f3 = F3_AND;
      K_LB, K_SB:             f3 = F3_B;
      K_LH, K_SH:             f3 = F3_H;
      K_LW, K_SW:             f3 = F3_W;
      K_LBU:                  f3 = F3_BU;
      K_LHU:                  f3 = F3_HU;
      K_BEQ:                  f3 = F3_BEQ;
      K_BNE:                  f3 = F3_BNE;
      K_BLT:                  f3 = F3_BLT;
      K_BGE:                  f3 = F3_BGE;
      K_BLTU:                 f3 = F3_BLTU;
      K_BGEU:                 f3 = F3_BGEU;
      K_JALR, K_ECALL, K_EBREAK: f3 = F3_ZERO;
      default:                set_f3 = 1'b0;
    endcase
    if (k >= K_ADD && k <= K_AND) begin
      opc = OPC_OP;
      set_f7 = 1'b1;
    end else if (k >= K_ADDI && k <= K_ANDI) begin
      opc = OPC_OP_IMM;
    end else if (k >= K_SLLI && k <= K_SRAI) begin
      opc = OPC_OP_IMM;
      set_f7 = 1'b1;
    end else if (k >= K_LB && k <= K_LHU) begin
      opc = OPC_LOAD;
    end else if (k >= K_SB && k <= K_SW) begin
      opc = OPC_STORE;
    end else if (k >= K_BEQ && k <= K_BGEU) begin
      opc = OPC_BRANCH;
    end else if (k == K_LUI) begin
      opc = OPC_LUI;
    end else if (k == K_AUIPC) begin
      opc = OPC_AUIPC;
    end else if (k == K_JAL) begin
      opc = OPC_JAL;
    end else if (k == K_JALR) begin
      opc = OPC_JALR;
    end else begin
      opc = OPC_SYSTEM;
    end
    w[6:0] = opc;
    if (set_f3)
      w[14:12] = f3;
    if (set_f7)
      w[31:25] = (k inside {K_SUB, K_SRA, K_SRAI}) ? F7_ALT : F7_BASE;
    if (k == K_ECALL)
      w[31:20] = SYS_ECALL;
    else if (k == K_EBREAK)
      w[31:20] = SYS_EBREAK;
    return w;
  endfunction

  function automatic kind_t random_kind();
    return kind_t'(6'($urandom_range(K_ADD, K_EBREAK)));
  endfunction

  task automatic queue_word(logic [31:0] w, bit drain);
    word_item_t it;
    it.word = w;
    it.wait_drain = drain;
    word_q.push_back(it);
  endtask

  // ---------------------------------------------------------------------------
  // checking: one line per mismatch
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] word, logic [31:0] got,
                                 logic [31:0] want);
    mismatch_cnt++;
    $display("%0t: mismatch %s for word %h: got %h, expected %h",
             $time, what, word, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] word, logic [31:0] got,
                             logic [31:0] want);
    if (got !== want)
      report_mismatch(what, word, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of words from word_q with random gaps in between
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    bit         taken;
    word_item_t nxt;
    if (rst) begin
      instr_ch.valid <= 1'b0;
      instr_ch.instr_word <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      taken = instr_ch.valid && instr_ch.ready;
      // a word on offer stays put until it is taken
      if (!instr_ch.valid || taken) begin
        if (gap_left != 0) begin
          gap_left--;
          instr_ch.valid <= 1'b0;
        end else if (word_q.size() == 0) begin
          instr_ch.valid <= 1'b0;
        end else if (word_q[0].wait_drain && (taken || !pipe_empty)) begin
          // pause until every decoded record has come back
          instr_ch.valid <= 1'b0;
        end else begin
          nxt = word_q.pop_front();
          instr_ch.valid <= 1'b1;
          instr_ch.instr_word <= nxt.word;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            // about a third of the bursts run straight into the next one
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: its own stall pattern, plus long hold-offs that back the block up
  // ---------------------------------------------------------------------------
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 300;

  always @(posedge clk) begin
    if (rst) begin
      dec_ch.ready <= 1'b0;
    end else begin
      if (hold_left == 0 && words_accepted >= next_hold_at) begin
        hold_left = HOLD_LEN;
        next_hold_at = next_hold_at + HOLD_EVERY;
      end
      if (hold_left != 0) begin
        // sender keeps offering meanwhile, so the block fills and drops its ready
        hold_left--;
        dec_ch.ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          rx_left = $urandom_range(16, 80);
        end
        rx_left--;
        case (rx_mode)
          RX_OPEN:     dec_ch.ready <= 1'b1;
          RX_COIN:     dec_ch.ready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: dec_ch.ready <= (rx_left % 4 != 0);
          default:     dec_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on every accepted word, compares on every accepted record
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    decoded_item_t want;
    decoded_item_t got_for;
    if (!rst) begin
      if (instr_ch.valid && instr_ch.ready) begin
        want.word = instr_ch.instr_word;
        want.rec = decode_word(instr_ch.instr_word);
        decoded_q.push_back(want);
        words_accepted <= words_accepted + 1;
      end
      if (dec_ch.valid && dec_ch.ready) begin
        results_seen <= results_seen + 1;
        if (decoded_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", '0,
                          32'(dec_ch.instr_kind), '0);
        end else begin
          got_for = decoded_q.pop_front();
          kinds_hit[got_for.rec.kind] = 1'b1;
          if (got_for.rec.kind == K_INVALID)
            invalid_cnt++;
          check_field("instr_kind", got_for.word, 32'(dec_ch.instr_kind),
                      32'(got_for.rec.kind));
          check_field("instr_format", got_for.word, 32'(dec_ch.instr_format),
                      32'(got_for.rec.format));
          check_field("dest_reg", got_for.word, 32'(dec_ch.dest_reg),
                      32'(got_for.rec.dest_reg));
          check_field("src_reg_a", got_for.word, 32'(dec_ch.src_reg_a),
                      32'(got_for.rec.src_reg_a));
          check_field("src_reg_b", got_for.word, 32'(dec_ch.src_reg_b),
                      32'(got_for.rec.src_reg_b));
          check_field("imm_value", got_for.word, dec_ch.imm_value,
                      got_for.rec.imm_value);
          check_field("alu_select", got_for.word, 32'(dec_ch.alu_select),
                      32'(got_for.rec.alu));
          check_field("wb_source", got_for.word, 32'(dec_ch.wb_source),
                      32'(got_for.rec.wb));
          check_field("ctrl_flags", got_for.word, 32'(dec_ch.ctrl_flags),
                      32'(got_for.rec.flags));
          check_field("mem_width", got_for.word, 32'(dec_ch.mem_width),
                      32'(got_for.rec.mem_width));
          check_field("branch_cond", got_for.word, 32'(dec_ch.branch_cond),
                      32'(got_for.rec.branch_cond));
        end
      end
      pipe_empty <= (decoded_q.size() == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] w;
    int unsigned sel;
    int unsigned n_words;

    instr_ch.valid = 1'b0;
    instr_ch.instr_word = '0;
    dec_ch.ready = 1'b0;
    rst = 1'b1;

    // directed corners
    queue_word(32'h0000_0000, 1'b0);                                    // unknown opcode, zeros
    queue_word(32'hffff_ffff, 1'b0);                                    // unknown opcode, ones
    queue_word(enc_i(12'hfff, 5'd31, F3_ADD_SUB, 5'd31, OPC_OP_IMM), 1'b0); // addi -1
    queue_word(enc_i(12'h7ff, 5'd0, F3_ADD_SUB, 5'd0, OPC_OP_IMM), 1'b0);   // largest imm
    queue_word(enc_i(12'h800, 5'd1, F3_AND, 5'd2, OPC_OP_IMM), 1'b0);       // most negative
    queue_word(enc_i({F7_BASE, 5'd31}, 5'd7, F3_SLL, 5'd3, OPC_OP_IMM), 1'b0);
    // srai: alt funct7 must not leak into the masked shift amount
    queue_word(enc_i({F7_ALT, 5'd31}, 5'd8, F3_SR, 5'd9, OPC_OP_IMM), 1'b0);
    // shift-immediate with bad funct7: invalid, full sign-extended immediate
    queue_word(enc_i({F7_BAD, 5'd4}, 5'd10, F3_SR, 5'd11, OPC_OP_IMM), 1'b0);
    queue_word(enc_i({F7_ALT, 5'd9}, 5'd12, F3_SLL, 5'd13, OPC_OP_IMM), 1'b0);
    queue_word(enc_i({F7_ALT, 5'd31}, 5'd31, F3_SR, 5'd31, OPC_OP), 1'b0);    // sra
    queue_word(enc_i({7'h7f, 5'd5}, 5'd6, F3_ADD_SUB, 5'd7, OPC_OP), 1'b0);   // bad funct7
    queue_word(enc_i({F7_ALT, 5'd5}, 5'd6, F3_OR, 5'd7, OPC_OP), 1'b0);       // alt on or
    queue_word(enc_i(12'hfff, 5'd31, F3_BAD_LOAD, 5'd31, OPC_LOAD), 1'b0);
    queue_word(enc_i(12'h800, 5'd3, F3_HU, 5'd4, OPC_LOAD), 1'b0);
    queue_word({7'h7f, 5'd31, 5'd31, F3_W, 5'h1f, OPC_STORE}, 1'b0);           // sw -1
    queue_word({7'h40, 5'd0, 5'd0, F3_B, 5'h00, OPC_STORE}, 1'b0);             // sb min
    queue_word({7'h3f, 5'd1, 5'd2, F3_BAD_STORE, 5'h1f, OPC_STORE}, 1'b0);
    queue_word({1'b0, 6'h3f, 5'd31, 5'd0, F3_BGEU, 4'hf, 1'b1, OPC_BRANCH}, 1'b0);
    queue_word({1'b1, 6'h00, 5'd0, 5'd31, F3_BEQ, 4'h0, 1'b0, OPC_BRANCH}, 1'b0);
    queue_word({1'b1, 6'h3f, 5'd31, 5'd31, F3_BAD_BRANCH, 4'hf, 1'b1, OPC_BRANCH}, 1'b0);
    queue_word({20'hfffff, 5'd31, OPC_JAL}, 1'b0);
    queue_word({1'b1, 10'h000, 1'b0, 8'h00, 5'd1, OPC_JAL}, 1'b0);             // jal min
    queue_word({1'b0, 10'h3ff, 1'b1, 8'hff, 5'd0, OPC_JAL}, 1'b0);             // jal max
    queue_word({20'hfffff, 5'd0, OPC_LUI}, 1'b0);
    queue_word({20'h80000, 5'd31, OPC_AUIPC}, 1'b0);
    queue_word(enc_i(12'h7ff, 5'd5, F3_BAD_JALR, 5'd1, OPC_JALR), 1'b0);
    // system: plain ecall/ebreak, ecall with rd/rs1 set, and near misses
    queue_word(enc_i(SYS_ECALL, 5'd0, F3_ZERO, 5'd0, OPC_SYSTEM), 1'b0);
    queue_word(enc_i(SYS_EBREAK, 5'd0, F3_ZERO, 5'd0, OPC_SYSTEM), 1'b0);
    queue_word(enc_i(SYS_ECALL, 5'd31, F3_ZERO, 5'd31, OPC_SYSTEM), 1'b0);
    queue_word(enc_i(12'h002, 5'd0, F3_ZERO, 5'd0, OPC_SYSTEM), 1'b0);
    queue_word(enc_i(12'hfff, 5'd0, F3_ZERO, 5'd0, OPC_SYSTEM), 1'b0);
    queue_word(enc_i(SYS_ECALL, 5'd0, F3_CSRRW, 5'd0, OPC_SYSTEM), 1'b0);

    // every kind once with random operands, after an empty pipe
    for (int k = K_ADD; k <= K_EBREAK; k++)
      queue_word(make_word(kind_t'(k[5:0]), $urandom), k == K_ADD);

    // random words: mostly well-formed, some with broken funct bits, some noise
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      sel = $urandom_range(0, 99);
      w = make_word(random_kind(), $urandom);
      if (sel >= 85) begin
        w = $urandom;
      end else if (sel >= 70) begin
        w[14:12] = 3'($urandom);
        w[31:25] = 7'($urandom);
      end
      queue_word(w, n % DRAIN_EVERY == 0);
    end
    n_words = word_q.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // every word decoded and taken back, then a quiet tail for strays
    while (results_seen < n_words) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("decoded %0d words, %0d records checked, %0d mismatches",
             words_accepted, results_seen, mismatch_cnt);
    $display("%0d of 39 instruction kinds seen, %0d invalid words, %0d left outstanding",
             $countones(kinds_hit[39:1]), invalid_cnt, decoded_q.size());
    if (mismatch_cnt == 0 && decoded_q.size() == 0 && results_seen == n_words)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout: %0d words accepted, %0d records back", words_accepted, results_seen);
    $display("FAILURE");
    $finish;
  end

endmodule
